// ----- hdl/tpst_pkg.sv -----
// shared types, constants and helpers of the two-partition slot table
package tpst_pkg;

  localparam int SLOTS       = 64;
  localparam int MAX_OBJECTS = 256;
  localparam int ADDR_W      = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int OBJ_W       = $clog2(MAX_OBJECTS);
  localparam int CAP_W       = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_ACT    = 2'd2,
    KIND_DEACT  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2,
    STAT_NOOP = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SECOND
  } state_t;

  // request from the sequencer to the slot memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [OBJ_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } mem_req_t;

  // zero reads as one, anything above the table size is clipped
  function automatic logic [CNT_W-1:0] cap_limit(input logic [CAP_W-1:0] v);
    logic [CNT_W-1:0] c;
    if (v == '0) begin
      c = CNT_W'(1);
    end else if (32'(v) > SLOTS) begin
      c = CNT_W'(SLOTS);
    end else begin
      c = CNT_W'(v);
    end
    return c;
  endfunction

endpackage

// ----- hdl/tpst_ram.sv -----
// generic memory: one write port, two registered read ports
module tpst_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- hdl/tpst_seq.sv -----
// operation sequencer: partition counts, swap-remove decisions, result registers
module tpst_seq import tpst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind,
  input  logic [OBJ_W-1:0]  object,
  input  logic [ADDR_W-1:0] slot,
  output logic              done,
  output logic [1:0]        status,
  output logic [OBJ_W-1:0]  placed_object,
  output logic [ADDR_W-1:0] new_slot,
  output logic              moved,
  output logic              last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_data,
  output mem_req_t          mem_req,
  input  logic [OBJ_W-1:0]  rd_a_data,
  input  logic [OBJ_W-1:0]  rd_b_data
);

  state_t state, state_next;

  logic [CNT_W-1:0]  cap, ac, ic;
  kind_t             op_kind;
  logic [OBJ_W-1:0]  op_object;
  logic [ADDR_W-1:0] op_slot;
  logic [OBJ_W-1:0]  sec_obj;
  logic [ADDR_W-1:0] sec_slot;

  // decision of the execute cycle
  logic [CNT_W-1:0]  top_slot, edge_act, slot_ext, ac_next, ic_next;
  logic              is_act, is_inact;
  status_t           p_status;
  logic [OBJ_W-1:0]  p_obj;
  logic [ADDR_W-1:0] p_slot;
  logic              p_moved, w1_en, p_sec;
  logic [ADDR_W-1:0] w1_addr;
  logic [OBJ_W-1:0]  w1_data;
  logic [CNT_W:0]    fill;

  // read address for the edge entry, taken from the live inputs at accept
  logic [CNT_W-1:0]  in_ext, in_edge;

  always_comb begin
    in_ext = CNT_W'(slot);
    if (kind_t'(kind) == KIND_DEACT || (kind_t'(kind) == KIND_DELETE && in_ext < ac)) begin
      in_edge = ac - CNT_W'(1);
    end else begin
      in_edge = cap - ic;
    end
  end

  always_comb begin
    top_slot = cap - ic;
    edge_act = ac - CNT_W'(1);
    slot_ext = CNT_W'(op_slot);
    is_act   = slot_ext < ac;
    is_inact = (slot_ext >= top_slot) && (slot_ext < cap);
    fill     = {1'b0, ac} + {1'b0, ic};
    p_status = STAT_OK;
    p_obj    = '0;
    p_slot   = '0;
    p_moved  = 1'b0;
    w1_en    = 1'b0;
    w1_addr  = op_slot;
    w1_data  = rd_b_data;
    p_sec    = 1'b0;
    ac_next  = ac;
    ic_next  = ic;
    if (op_kind == KIND_ADD) begin
      if (fill >= {1'b0, cap}) begin
        p_status = STAT_FULL;
      end else begin
        w1_en   = 1'b1;
        w1_addr = ADDR_W'(ac);
        w1_data = op_object;
        p_obj   = op_object;
        p_slot  = ADDR_W'(ac);
        p_moved = 1'b1;
        ac_next = ac + CNT_W'(1);
      end
    end else if (!is_act && !is_inact) begin
      p_status = STAT_BAD;
    end else begin
      unique case (op_kind)
        KIND_DELETE: begin
          if (is_act) begin
            ac_next = ac - CNT_W'(1);
          end else begin
            ic_next = ic - CNT_W'(1);
          end
          if (slot_ext != (is_act ? edge_act : top_slot)) begin
            // edge handle fills the hole
            w1_en   = 1'b1;
            p_obj   = rd_b_data;
            p_slot  = op_slot;
            p_moved = 1'b1;
          end
        end
        KIND_ACT: begin
          if (is_act) begin
            p_status = STAT_NOOP;
          end else begin
            w1_en   = 1'b1;
            w1_addr = ADDR_W'(ac);
            w1_data = rd_a_data;
            p_obj   = rd_a_data;
            p_slot  = ADDR_W'(ac);
            p_moved = 1'b1;
            p_sec   = slot_ext != top_slot;
            ac_next = ac + CNT_W'(1);
            ic_next = ic - CNT_W'(1);
          end
        end
        KIND_DEACT: begin
          if (!is_act) begin
            p_status = STAT_NOOP;
          end else begin
            w1_en   = 1'b1;
            w1_addr = ADDR_W'(top_slot - CNT_W'(1));
            w1_data = rd_a_data;
            p_obj   = rd_a_data;
            p_slot  = ADDR_W'(top_slot - CNT_W'(1));
            p_moved = 1'b1;
            p_sec   = slot_ext != edge_act;
            ac_next = ac - CNT_W'(1);
            ic_next = ic + CNT_W'(1);
          end
        end
        default: begin
          p_status = STAT_OK;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_EXEC;
      S_EXEC:   state_next = p_sec ? S_SECOND : S_IDLE;
      S_SECOND: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy            = state != S_IDLE;
    // a command offered in the same cycle goes first
    cfg_ready       = (state == S_IDLE) && !start;
    mem_req.raddr_a = slot;
    mem_req.raddr_b = ADDR_W'(in_edge);
    mem_req.we      = 1'b0;
    mem_req.waddr   = w1_addr;
    mem_req.wdata   = w1_data;
    unique case (state)
      S_IDLE: mem_req.we = 1'b0;
      S_EXEC: mem_req.we = w1_en;
      S_SECOND: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = sec_slot;
        mem_req.wdata = sec_obj;
      end
      default: mem_req.we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cap   <= cap_limit(CAP_RESET);
      ac    <= '0;
      ic    <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC) || (state == S_SECOND);
      if (cfg_valid && cfg_ready) begin
        cap <= cap_limit(cfg_data);
        ac  <= '0;
        ic  <= '0;
      end else if (state == S_EXEC) begin
        ac <= ac_next;
        ic <= ic_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_kind   <= kind_t'(kind);
      op_object <= object;
      op_slot   <= slot;
    end
    if (state == S_EXEC) begin
      sec_obj       <= rd_b_data;
      sec_slot      <= op_slot;
      status        <= p_status;
      placed_object <= p_obj;
      new_slot      <= p_slot;
      moved         <= p_moved;
      last          <= !p_sec;
    end else if (state == S_SECOND) begin
      status        <= STAT_OK;
      placed_object <= sec_obj;
      new_slot      <= sec_slot;
      moved         <= 1'b1;
      last          <= 1'b1;
    end
  end

endmodule

// ----- hdl/two_partition_slot_table_unit.sv -----
// top level of the two-partition slot table
//
// slot table of object handles: active handles packed from slot 0 up, inactive
// handles packed from slot capacity-1 down, free slots in between
// command channel: an item transfers at a rising edge with start high and busy
// low; kind selects add, delete, activate or deactivate, object is the handle to
// add, slot the entry to work on
// result channel: each result is on status/placed_object/new_slot/moved/last for
// one cycle with done high; the receiver has no way to stall it
// timing: the slot reads are registered at the item transfer and the first result
// is registered from the execute state; a second result (activate or deactivate
// with a real hole to fill) follows in the next cycle
// no new item is taken before the last write of the current one, set by the
// single write port of the slot memory (read both slots, then one write a cycle)
// config channel: cfg_data is the capacity, taken when cfg_valid and cfg_ready
// are high; it empties both partitions; cfg_ready is high only while idle and
// no command is offered
// reset: synchronous, clears both counts and sets capacity to 64; the slot
// memory itself is not cleared and needs no clearing pass
module two_partition_slot_table_unit import tpst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind,
  input  logic [OBJ_W-1:0]  object,
  input  logic [ADDR_W-1:0] slot,
  output logic              done,
  output logic [1:0]        status,
  output logic [OBJ_W-1:0]  placed_object,
  output logic [ADDR_W-1:0] new_slot,
  output logic              moved,
  output logic              last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_data
);

  // memory request from the sequencer and the two registered read words
  mem_req_t         mem_req;
  logic [OBJ_W-1:0] rd_a_data, rd_b_data;

  // sequencer: reads the target slot and the partition edge at transfer,
  // writes the placements back one per cycle afterwards
  tpst_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .object        (object),
    .slot          (slot),
    .done          (done),
    .status        (status),
    .placed_object (placed_object),
    .new_slot      (new_slot),
    .moved         (moved),
    .last          (last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mem_req       (mem_req),
    .rd_a_data     (rd_a_data),
    .rd_b_data     (rd_b_data)
  );

  // slot store: handles per slot, no reset, registered reads
  tpst_ram #(
    .DEPTH (SLOTS),
    .WIDTH (OBJ_W)
  ) u_ram (
    .clk     (clk),
    .we      (mem_req.we),
    .waddr   (mem_req.waddr),
    .wdata   (mem_req.wdata),
    .raddr_a (mem_req.raddr_a),
    .raddr_b (mem_req.raddr_b),
    .rdata_a (rd_a_data),
    .rdata_b (rd_b_data)
  );

endmodule

// ----- hdl/tpst_chk.sv -----
// port-level checks of the slot table, bound to the top level
module tpst_chk import tpst_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [1:0]        status,
  input logic              moved,
  input logic              last
);

  // an accepted command keeps the unit busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("unit not busy after command transfer");

  // a first of two results is followed at once by the second
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    done && !last |=> done && last)
    else $error("second result missing");

  // results with no placement always close their command
  a_unmoved_last: assert property (@(posedge clk) disable iff (rst)
    done && !moved |-> last)
    else $error("unmoved result not final");

  // faults never report a placement
  a_fault_unmoved: assert property (@(posedge clk) disable iff (rst)
    done && status != STAT_OK |-> !moved)
    else $error("placement reported with fault status");

  // results come only out of a busy cycle
  a_done_from_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a command in progress");

endmodule

bind two_partition_slot_table_unit tpst_chk u_chk (.*);
